[rtl/island_sleep_detector_unit_assert.svh]
// assertion macros for the island sleep detector
`ifndef ISLAND_SLEEP_DETECTOR_UNIT_ASSERT_SVH
`define ISLAND_SLEEP_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ISD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ISD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/isd_pkg.sv]
// shared constants and types for the island sleep detector
package isd_pkg;

    localparam int FRAC_BITS_DEFAULT   = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int STEP_TIME_RESET  = 1092;
    localparam int SLEEP_TIME_RESET = 32768;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TIME = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_W,
        ST_SQRT,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_ACC
    } mul_phase_t;

endpackage

[rtl/island_sleep_detector_unit.sv]
// top level of the island sleep detector: sequencer, datapath and ports
// an awake live dynamic member runs three products and the root between accept and result;
// any other member goes straight to the update and finish steps
// one item is worked on at a time
// the result sits in an output register, so the next item is taken while it waits
// aresetn is synchronous, active low: config returns to its defaults, island flags clear
`include "island_sleep_detector_unit_assert.svh"

module island_sleep_detector_unit #(
    parameter int FRAC_BITS   = isd_pkg::FRAC_BITS_DEFAULT,
    parameter int VALUE_WIDTH = isd_pkg::VALUE_WIDTH_DEFAULT,
    localparam int S_DATA_W   = ((6 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // member input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vel_x, vel_y, spin, extent, speed_limit, timer_in (low bits first)
    input  logic [S_DATA_W-1:0]             s_tdata,
    // live_dynamic, is_awake, has_joint (low bits first)
    input  logic [2:0]                      s_tuser,
    input  logic                            s_tlast,

    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // timer_out
    output logic [M_DATA_W-1:0]             m_tdata,
    // island_sleeps
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast,

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [isd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]          cfg_data
);

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] VMAX = '1;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        logic [W-1:0] r;
        r = v[W-1] ? (~v + W'(1)) : v;
        return r;
    endfunction

    // input fields
    logic [W-1:0] in_vel_x, in_vel_y, in_spin, in_extent, in_limit, in_timer;
    logic         in_live, in_awake, in_joint, in_act;

    assign in_vel_x  = s_tdata[0*W +: W];
    assign in_vel_y  = s_tdata[1*W +: W];
    assign in_spin   = s_tdata[2*W +: W];
    assign in_extent = s_tdata[3*W +: W];
    assign in_limit  = s_tdata[4*W +: W];
    assign in_timer  = s_tdata[5*W +: W];
    assign in_live   = s_tuser[0];
    assign in_awake  = s_tuser[1];
    assign in_joint  = s_tuser[2];
    assign in_act    = in_live & in_awake;

    // control and stored item
    isd_pkg::state_t state_reg, state_next;

    logic [W-1:0]   step_time_reg, sleep_time_reg;
    logic           any_awake_reg, all_idle_reg;
    logic           live_reg, awake_reg, joint_reg, last_reg;
    logic [W-1:0]   my_reg, mw_reg, ext_reg, limit_reg, timer_in_reg;
    logic [2*W-1:0] sq_sum_reg;
    logic [W-1:0]   ang_reg, speed_reg, timer_reg;

    logic           m_valid_reg, out_sleeps_reg, out_last_reg;
    logic [W-1:0]   out_timer_reg;

    // shared units
    logic           mul_start, mul_done;
    logic [W-1:0]   mul_a, mul_b;
    logic [2*W-1:0] mul_product;
    logic           sqrt_start, sqrt_done;
    logic [W-1:0]   sqrt_root;

    isd_mul #(.VALUE_WIDTH(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    isd_sqrt #(.VALUE_WIDTH(W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // output register is free when empty or being drained this cycle
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer: vx^2, vy^2, |w|*extent on the multiplier, then the root
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            isd_pkg::ST_IDLE: begin
                mul_a = magnitude(in_vel_x);
                mul_b = magnitude(in_vel_x);
                if (s_tvalid) begin
                    mul_start  = in_act;
                    state_next = in_act ? isd_pkg::ST_MUL_X : isd_pkg::ST_UPDATE;
                end
            end
            isd_pkg::ST_MUL_X: begin
                mul_a = my_reg;
                mul_b = my_reg;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = isd_pkg::ST_MUL_Y;
                end
            end
            isd_pkg::ST_MUL_Y: begin
                mul_a = mw_reg;
                mul_b = ext_reg;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = isd_pkg::ST_MUL_W;
                end
            end
            isd_pkg::ST_MUL_W: begin
                if (mul_done) begin
                    sqrt_start = 1'b1;
                    state_next = isd_pkg::ST_SQRT;
                end
            end
            isd_pkg::ST_SQRT: begin
                if (sqrt_done) state_next = isd_pkg::ST_UPDATE;
            end
            isd_pkg::ST_UPDATE: begin
                state_next = isd_pkg::ST_FINISH;
            end
            isd_pkg::ST_FINISH: begin
                if (out_free) state_next = isd_pkg::ST_IDLE;
            end
            default: state_next = isd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == isd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // angular term: truncate by FRAC_BITS, saturate to the value width
    logic [2*W-1:0] ang_shift;
    logic [W-1:0]   ang_sat;
    assign ang_shift = mul_product >> FRAC_BITS;
    assign ang_sat   = (|ang_shift[2*W-1:W]) ? VMAX : ang_shift[W-1:0];

    // speed = root + angular term, saturating
    logic [W:0]   speed_sum;
    logic [W-1:0] speed_sat;
    assign speed_sum = {1'b0, sqrt_root} + {1'b0, ang_reg};
    assign speed_sat = speed_sum[W] ? VMAX : speed_sum[W-1:0];

    // timer update: a jointed live body starts from zero
    logic [W-1:0] timer_base, timer_sat, timer_new;
    logic [W:0]   timer_sum;
    assign timer_base = (live_reg && joint_reg) ? '0 : timer_in_reg;
    assign timer_sum  = {1'b0, timer_base} + {1'b0, step_time_reg};
    assign timer_sat  = timer_sum[W] ? VMAX : timer_sum[W-1:0];
    always_comb begin
        timer_new = timer_base;
        if (live_reg && awake_reg) begin
            timer_new = (speed_reg < limit_reg) ? timer_sat : '0;
        end
    end

    // island flags after this member
    logic member_act, any_next, idle_next;
    assign member_act = live_reg & awake_reg;
    assign any_next   = any_awake_reg | member_act;
    assign idle_next  = all_idle_reg & ~(member_act & (timer_reg <= sleep_time_reg));

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == isd_pkg::ST_IDLE && s_tvalid) begin
            live_reg     <= in_live;
            awake_reg    <= in_awake;
            joint_reg    <= in_joint;
            last_reg     <= s_tlast;
            my_reg       <= magnitude(in_vel_y);
            mw_reg       <= magnitude(in_spin);
            ext_reg      <= in_extent;
            limit_reg    <= in_limit;
            timer_in_reg <= in_timer;
        end
        if (state_reg == isd_pkg::ST_MUL_X && mul_done) begin
            sq_sum_reg <= mul_product;
        end
        if (state_reg == isd_pkg::ST_MUL_Y && mul_done) begin
            sq_sum_reg <= sq_sum_reg + mul_product;
        end
        if (state_reg == isd_pkg::ST_MUL_W && mul_done) begin
            ang_reg <= ang_sat;
        end
        if (state_reg == isd_pkg::ST_SQRT && sqrt_done) begin
            speed_reg <= speed_sat;
        end
        if (state_reg == isd_pkg::ST_UPDATE) begin
            timer_reg <= timer_new;
        end
        if (state_reg == isd_pkg::ST_FINISH && out_free) begin
            out_timer_reg  <= timer_reg;
            out_sleeps_reg <= last_reg & any_next & idle_next;
            out_last_reg   <= last_reg;
        end
    end

    // config registers, island flags, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg  <= W'(isd_pkg::STEP_TIME_RESET);
            sleep_time_reg <= W'(isd_pkg::SLEEP_TIME_RESET);
            any_awake_reg  <= 1'b0;
            all_idle_reg   <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    isd_pkg::REG_STEP_TIME:  step_time_reg  <= cfg_data;
                    isd_pkg::REG_SLEEP_TIME: sleep_time_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == isd_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                // flags start over after the last member of an island
                any_awake_reg <= last_reg ? 1'b0 : any_next;
                all_idle_reg  <= last_reg ? 1'b1 : idle_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = M_DATA_W'(out_timer_reg);
    assign m_tuser[0] = out_sleeps_reg;
    assign m_tlast    = out_last_reg;

    // checks
    logic chk_skip, chk_at_update, chk_in_mul, chk_in_sqrt, chk_restart, chk_flags_clear;
    assign chk_skip        = s_tvalid && s_tready && !in_act;
    assign chk_at_update   = (state_reg == isd_pkg::ST_UPDATE);
    assign chk_in_mul      = (state_reg == isd_pkg::ST_MUL_X) || (state_reg == isd_pkg::ST_MUL_Y)
                             || (state_reg == isd_pkg::ST_MUL_W);
    assign chk_in_sqrt     = (state_reg == isd_pkg::ST_SQRT);
    assign chk_restart     = (state_reg == isd_pkg::ST_FINISH) && out_free && last_reg;
    assign chk_flags_clear = !any_awake_reg && all_idle_reg;

    `ISD_ASSERT_NEXT(a_skip_path, chk_skip, chk_at_update, "inactive item did not skip speed")
    `ISD_ASSERT_NOW(a_mul_done_state, mul_done, chk_in_mul, "product done outside multiply")
    `ISD_ASSERT_NOW(a_sqrt_done_state, sqrt_done, chk_in_sqrt, "root done outside root step")
    `ISD_ASSERT_NEXT(a_flags_restart, chk_restart, chk_flags_clear, "island flags not restarted")

endmodule

[rtl/isd_mul.sv]
// shared multiplier: full product from two half-width partial products
module isd_mul #(
    parameter int VALUE_WIDTH = isd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [VALUE_WIDTH-1:0]     a,
    input  logic [VALUE_WIDTH-1:0]     b,
    output logic                       done,
    output logic [2*VALUE_WIDTH-1:0]   product
);

    localparam int H  = (VALUE_WIDTH + 1) / 2;
    localparam int PW = VALUE_WIDTH + H;

    isd_pkg::mul_phase_t phase_reg, phase_next;
    logic                     done_reg;
    logic [VALUE_WIDTH-1:0]   a_reg, b_reg;
    logic [PW-1:0]            pp_reg;
    logic [2*VALUE_WIDTH-1:0] acc_reg;
    logic [H-1:0]             mul_b;

    // low half first, then the high half
    assign mul_b = (phase_reg == isd_pkg::MP_HI) ? H'(b_reg[VALUE_WIDTH-1:H]) : b_reg[H-1:0];

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            isd_pkg::MP_IDLE: if (start) phase_next = isd_pkg::MP_LO;
            isd_pkg::MP_LO:   phase_next = isd_pkg::MP_HI;
            isd_pkg::MP_HI:   phase_next = isd_pkg::MP_ACC;
            isd_pkg::MP_ACC:  phase_next = isd_pkg::MP_IDLE;
            default:          phase_next = isd_pkg::MP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= isd_pkg::MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == isd_pkg::MP_ACC);
        end
    end

    always_ff @(posedge aclk) begin
        if (start && phase_reg == isd_pkg::MP_IDLE) begin
            a_reg <= a;
            b_reg <= b;
        end
        if (phase_reg == isd_pkg::MP_LO || phase_reg == isd_pkg::MP_HI) begin
            pp_reg <= PW'(a_reg) * PW'(mul_b);
        end
        if (phase_reg == isd_pkg::MP_HI) begin
            acc_reg <= (2*VALUE_WIDTH)'(pp_reg);
        end
        if (phase_reg == isd_pkg::MP_ACC) begin
            acc_reg <= acc_reg + ((2*VALUE_WIDTH)'(pp_reg) << H);
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/isd_sqrt.sv]
// bit-serial integer square root, one root bit per cycle
module isd_sqrt #(
    parameter int VALUE_WIDTH = isd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2*VALUE_WIDTH-1:0]   radicand,
    output logic                       done,
    output logic [VALUE_WIDTH-1:0]     root
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int RW = VALUE_WIDTH + 2;

    logic [CW-1:0]            cnt_reg;
    logic                     done_reg;
    logic [2*VALUE_WIDTH-1:0] rad_reg;
    logic [RW-1:0]            rem_reg;
    logic [VALUE_WIDTH-1:0]   root_reg;
    logic [RW-1:0]            rem_sh, trial;
    logic                     fits;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_reg[VALUE_WIDTH-1:0], rad_reg[2*VALUE_WIDTH-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CW'(1));
            if (start && cnt_reg == '0) begin
                cnt_reg <= CW'(VALUE_WIDTH);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && cnt_reg == '0) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[VALUE_WIDTH-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[tb/sv/island_verdict_checker.sv]
// checker for the island sleep detector: watches the channels, predicts each result, compares
`timescale 1ns / 1ps

module island_verdict_checker #(
    parameter int VW  = isd_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FB  = isd_pkg::FRAC_BITS_DEFAULT,
    parameter int S_W = ((6 * VW + 7) / 8) * 8,
    parameter int M_W = ((VW + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // vel_x, vel_y, spin, extent, speed_limit, timer_in (low bits first)
    input  logic [S_W-1:0]                  s_tdata,
    // live_dynamic, is_awake, has_joint (low bits first)
    input  logic [2:0]                      s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // timer_out
    input  logic [M_W-1:0]                  m_tdata,
    // island_sleeps
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [isd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [VW-1:0]                   cfg_data,
    output int                              pending,
    output int                              mismatches,
    output int                              results_seen,
    output int                              islands_seen,
    output int                              sleeps_seen
);

    localparam logic [VW-1:0] FULL = '1;

    typedef struct packed {
        logic [VW-1:0] timer;
        logic          sleeps;
        logic          last;
    } member_result_t;

    member_result_t verdict_q[$];

    logic [VW-1:0] step_reg;
    logic [VW-1:0] sleep_reg;
    logic          saw_awake;
    logic          all_rested;

    function automatic logic [VW-1:0] abs_q(logic [VW-1:0] v);
        return v[VW-1] ? (~v + VW'(1)) : v;
    endfunction

    function automatic logic [VW-1:0] sat_sum(logic [VW-1:0] a, logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VW] ? FULL : s[VW-1:0];
    endfunction

    // floor root of the squared linear speed plus truncated |spin| * extent, saturating
    function automatic logic [VW-1:0] motion_speed(logic [VW-1:0] vx, logic [VW-1:0] vy,
                                                   logic [VW-1:0] w, logic [VW-1:0] ext);
        logic [2*VW+1:0] ex;
        logic [2*VW+1:0] ey;
        logic [2*VW+1:0] ec;
        logic [2*VW+1:0] sq_sum;
        logic [VW:0]     root;
        logic [VW:0]     cand;
        logic [2*VW-1:0] ang_wide;
        logic [VW-1:0]   ang;
        logic [VW+1:0]   total;
        ex = (2*VW+2)'(abs_q(vx));
        ey = (2*VW+2)'(abs_q(vy));
        sq_sum = ex * ex + ey * ey;
        root = '0;
        for (int b = VW; b >= 0; b--) begin
            cand = root;
            cand[b] = 1'b1;
            ec = (2*VW+2)'(cand);
            if (ec * ec <= sq_sum)
                root = cand;
        end
        ang_wide = ({{VW{1'b0}}, abs_q(w)} * {{VW{1'b0}}, ext}) >> FB;
        ang = (|ang_wide[2*VW-1:VW]) ? FULL : ang_wide[VW-1:0];
        total = (VW+2)'(root) + (VW+2)'(ang);
        return (total > (VW+2)'(FULL)) ? FULL : total[VW-1:0];
    endfunction

    function automatic member_result_t predict_member(logic live, logic awake, logic joint,
                                                      logic [VW-1:0] vx, logic [VW-1:0] vy,
                                                      logic [VW-1:0] w, logic [VW-1:0] ext,
                                                      logic [VW-1:0] lim, logic [VW-1:0] tin,
                                                      logic last);
        member_result_t r;
        logic [VW-1:0]  t;
        t = tin;
        if (live && joint)
            t = '0;
        if (live && awake) begin
            t = (motion_speed(vx, vy, w, ext) < lim) ? sat_sum(t, step_reg) : '0;
            saw_awake = 1'b1;
            if (t <= sleep_reg)
                all_rested = 1'b0;
        end
        r.timer = t;
        r.last = last;
        r.sleeps = last && saw_awake && all_rested;
        if (last) begin
            saw_awake = 1'b0;
            all_rested = 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        member_result_t want;
        member_result_t got;
        if (!aresetn) begin
            step_reg = VW'(isd_pkg::STEP_TIME_RESET);
            sleep_reg = VW'(isd_pkg::SLEEP_TIME_RESET);
            saw_awake = 1'b0;
            all_rested = 1'b1;
            verdict_q.delete();
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    isd_pkg::REG_STEP_TIME:  step_reg = cfg_data;
                    isd_pkg::REG_SLEEP_TIME: sleep_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.timer = m_tdata[VW-1:0];
                got.sleeps = m_tuser[0];
                got.last = m_tlast;
                results_seen++;
                if (got.last)
                    islands_seen++;
                if (got.sleeps)
                    sleeps_seen++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: timer %h sleeps %0b last %0b",
                                 $realtime, got.timer, got.sleeps, got.last);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d: expected timer %h sleeps %0b last %0b, ",
                                     $realtime, results_seen, want.timer, want.sleeps,
                                     want.last, "got timer %h sleeps %0b last %0b",
                                     got.timer, got.sleeps, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_member(s_tuser[0], s_tuser[1], s_tuser[2],
                                                   s_tdata[VW-1:0], s_tdata[2*VW-1:VW],
                                                   s_tdata[3*VW-1:2*VW], s_tdata[4*VW-1:3*VW],
                                                   s_tdata[5*VW-1:4*VW], s_tdata[6*VW-1:5*VW],
                                                   s_tlast));
            pending = verdict_q.size();
        end
    end

endmodule

[tb/sv/tb_island_sleep_detector_unit.sv]
// testbench top for the island sleep detector: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_island_sleep_detector_unit;

    localparam int VW          = isd_pkg::VALUE_WIDTH_DEFAULT;
    localparam int S_W         = ((6 * VW + 7) / 8) * 8;
    localparam int M_W         = ((VW + 7) / 8) * 8;
    // bound on the slowest legal run: about 1400 items, each with the largest gap, work and stall
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 225;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [S_W-1:0]                  s_tdata;
    logic [2:0]                      s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [M_W-1:0]                  m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [isd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [VW-1:0]                   cfg_data;

    int pending;
    int mismatches;
    int results_seen;
    int islands_seen;
    int sleeps_seen;
    int cfg_writes;
    int cycle_count;

    // when set, neither side inserts gaps or stalls
    logic          no_gaps;
    // register values currently loaded, used to aim timers near the sleep threshold
    logic [VW-1:0] cur_step;
    logic [VW-1:0] cur_sleep;

    island_sleep_detector_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    island_verdict_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .islands_seen (islands_seen),
        .sleeps_seen  (sleeps_seen)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 17));
    endfunction

    // mostly full-range words, with the sign and saturation corners weighted up
    function automatic logic [VW-1:0] any_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // signed value within +-0.25, a body close to rest
    function automatic logic [VW-1:0] small_signed();
        logic [VW-1:0] v;
        v = $urandom_range(0, 32768);
        return v - 32'd16384;
    endfunction

    // timer a few steps either side of the sleep threshold, clamped to the word range
    function automatic logic [VW-1:0] near_sleep();
        longint t;
        t = longint'(cur_sleep) + longint'(int'($urandom_range(0, 8)) - 4) * longint'(cur_step);
        if (t < 0)
            return '0;
        if (t > longint'(32'hFFFF_FFFF))
            return '1;
        return t[VW-1:0];
    endfunction

    // one member over the input channel; entered and left at a falling edge
    task automatic send_member(input logic live, input logic awake, input logic joint,
                               input logic [VW-1:0] vx, input logic [VW-1:0] vy,
                               input logic [VW-1:0] w, input logic [VW-1:0] ext,
                               input logic [VW-1:0] lim, input logic [VW-1:0] tin,
                               input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {tin, lim, ext, w, vy, vx};
        s_tuser = {joint, awake, live};
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // hold the sender until every result is back, so the block is idle
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [isd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [VW-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_writes++;
        if (idx == isd_pkg::REG_STEP_TIME)
            cur_step = val;
        else
            cur_sleep = val;
    endtask

    // registers change only with the block idle
    task automatic apply_settings(input logic [VW-1:0] step_val, input logic [VW-1:0] sleep_val);
        drain();
        write_reg(isd_pkg::REG_STEP_TIME, step_val);
        write_reg(isd_pkg::REG_SLEEP_TIME, sleep_val);
        cfg_valid = 1'b0;
    endtask

    // island shapes: resting islands (mostly awake, slow, timers around the threshold),
    // mixed islands with wide values, and noise where flags and tlast are arbitrary
    task automatic send_island_member(input int kind, input logic closing);
        logic          live;
        logic          awake;
        logic          joint;
        logic          last;
        logic [VW-1:0] vx;
        logic [VW-1:0] vy;
        logic [VW-1:0] w;
        logic [VW-1:0] ext;
        logic [VW-1:0] lim;
        logic [VW-1:0] tin;
        if (kind < 5) begin
            live = 1'b1;
            awake = ($urandom_range(0, 9) != 0);
            joint = ($urandom_range(0, 7) == 0);
            vx = small_signed();
            vy = small_signed();
            w = small_signed();
            ext = $urandom_range(0, 131072);
            lim = $urandom_range(32'h8000, 32'h40000);
            tin = near_sleep();
            last = closing;
        end else if (kind < 8) begin
            live = ($urandom_range(0, 4) != 0);
            awake = ($urandom_range(0, 9) < 7);
            joint = ($urandom_range(0, 9) < 3);
            vx = $urandom_range(0, 1) ? any_word() : small_signed();
            vy = $urandom_range(0, 1) ? any_word() : small_signed();
            w = $urandom_range(0, 1) ? any_word() : small_signed();
            ext = any_word();
            lim = any_word();
            tin = $urandom_range(0, 1) ? near_sleep() : any_word();
            last = closing;
        end else begin
            {live, awake, joint} = 3'($urandom());
            vx = $urandom();
            vy = $urandom();
            w = $urandom();
            ext = $urandom();
            lim = $urandom();
            tin = $urandom();
            last = ($urandom_range(0, 3) == 0);
        end
        send_member(live, awake, joint, vx, vy, w, ext, lim, tin, last);
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int kind;
        int size;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            size = $urandom_range(1, 6);
            for (int k = 0; k < size; k++) begin
                // a stretch of back-to-back traffic every so often
                no_gaps = ((sent % 120) < 30);
                send_island_member(kind, k == size - 1);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // result side: random stall before each item, ready held until it is taken
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = isd_pkg::REG_STEP_TIME;
        cfg_data = '0;
        no_gaps = 1'b0;
        cur_step = VW'(isd_pkg::STEP_TIME_RESET);
        cur_sleep = VW'(isd_pkg::SLEEP_TIME_RESET);
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed members, reset register values
        // lone body, not live: timer passes unchanged, joint ignored, no awake member
        send_member(1'b0, 1'b1, 1'b1, '0, '0, '0, '0, '1, '1, 1'b1);
        // asleep and jointed: timer zeroed, no say in the verdict
        send_member(1'b1, 1'b0, 1'b1, '1, '1, '1, '1, '1, 32'h1234_5678, 1'b1);
        // asleep, not jointed: timer unchanged
        send_member(1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0, 32'h0001_0000, 1'b1);
        // at rest with a full timer: add saturates, island sleeps
        send_member(1'b1, 1'b1, 1'b0, '0, '0, '0, '0, 32'd1, '1, 1'b1);
        // jointed and awake: timer zeroed then gains one step, below the sleep time
        send_member(1'b1, 1'b1, 1'b1, '0, '0, '0, '0, 32'd1, '1, 1'b1);
        // most negative velocity and spin, full extent: speed saturates, never below limit
        send_member(1'b1, 1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1,
                    32'd1000, 1'b1);
        // exact 3-4-5 root equal to the limit: not idle
        send_member(1'b1, 1'b1, 1'b0, 32'h0003_0000, 32'hFFFC_0000, '0, '0, 32'h0005_0000,
                    32'h0001_0000, 1'b1);
        // one lsb more limit: idle
        send_member(1'b1, 1'b1, 1'b0, 32'h0003_0000, 32'hFFFC_0000, '0, '0, 32'h0005_0001,
                    32'h0001_0000, 1'b1);
        // spin of -1.0 over extent 2.0 just under the limit, timer crosses the threshold
        send_member(1'b1, 1'b1, 1'b0, '0, '0, 32'hFFFF_0000, 32'h0002_0000, 32'h0002_0001,
                    32'h0000_8000, 1'b1);
        // zero limit: zero speed is not below it
        send_member(1'b1, 1'b1, 1'b0, '0, '0, '0, '0, '0, 32'h0001_0000, 1'b1);
        // largest positive velocity and spin
        send_member(1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, '1,
                    32'h0002_0000, 1'b1);
        // angular term alone overflows the word
        send_member(1'b1, 1'b1, 1'b0, '0, '0, 32'h8000_0000, '1, '1, 32'h0002_0000, 1'b1);
        // timer lands exactly on the sleep time: not beyond it, no sleep
        send_member(1'b1, 1'b1, 1'b0, '0, '0, '0, '0, '1, 32'd32768 - 32'd1092, 1'b1);
        // three-member island: rested awake body, asleep body, dead body -> sleeps
        send_member(1'b1, 1'b1, 1'b0, 32'h0000_0100, '0, '0, '0, 32'h0001_0000,
                    32'h0001_0000, 1'b0);
        send_member(1'b1, 1'b0, 1'b0, '1, '1, '1, '1, '0, 32'd5, 1'b0);
        send_member(1'b0, 1'b1, 1'b0, '1, '1, '1, '1, '0, 32'd7, 1'b1);
        // two awake members, the second moving: no sleep
        send_member(1'b1, 1'b1, 1'b0, '0, '0, '0, '0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_member(1'b1, 1'b1, 1'b0, 32'h0010_0000, '0, '0, '0, 32'h0001_0000, '1, 1'b1);
        // island without a live member: no sleep
        send_member(1'b0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_member(1'b0, 1'b1, 1'b1, '1, '1, '1, '1, '1, '1, 1'b1);
        // state must be fresh for the next island after a sleeping one
        send_member(1'b1, 1'b1, 1'b0, '0, '0, '0, '0, 32'd1, '1, 1'b1);

        run_phase(PHASE_ITEMS);
        // zero step and zero sleep time: a timer must already be nonzero to count
        apply_settings('0, '0);
        run_phase(PHASE_ITEMS);
        // full scale on both: nothing can exceed the sleep time
        apply_settings('1, '1);
        run_phase(PHASE_ITEMS);
        // full step, sleep one below: every idle member saturates past it
        apply_settings('1, 32'hFFFF_FFFE);
        run_phase(PHASE_ITEMS);
        apply_settings($urandom_range(0, 32'h4000), $urandom_range(0, 32'h40000));
        run_phase(PHASE_ITEMS);
        // small step at 120 Hz with a longer sleep time
        apply_settings(32'd546, 32'h0001_8000);
        run_phase(PHASE_ITEMS);

        drain();
        repeat (80) @(negedge aclk);

        $display("covered %0d members in %0d islands, %0d of them put to sleep",
                 results_seen, islands_seen, sleeps_seen);
        $display("%0d register writes, step and sleep time from zero to full scale",
                 cfg_writes);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
